// File: sv/bgb_pkg.sv
// Package for the bitplane glyph blitter: item structs, register indexes,
// reset values, function codes and fixed widths. No dependencies.
package bgb_pkg;

  localparam int WORD_SHIFT = 4;
  localparam int ADDR_W     = 22;
  localparam int MASK_W     = 16;
  localparam int BITS_W     = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LOG2   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS  = 2'd3;

  // Register reset values
  localparam logic [1:0]  RST_PLANE_LOG2   = 2'd0;
  localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
  localparam logic [4:0]  RST_GLYPH_HEIGHT = 5'd8;
  localparam logic [12:0] RST_LINE_PIXELS  = 13'd640;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef struct packed {
    logic              func;
    logic [11:0]       pos_x;
    logic [9:0]        pos_y;
    logic [7:0]        char_code;
    logic [7:0]        fg_color;
    logic [3:0]        glyph_row;
    logic [BITS_W-1:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [MASK_W-1:0] bit_mask;
    logic [7:0]        plane_fill;
    logic              last;
  } out_item_t;

endpackage

// File: sv/bgb_glyph_store.sv
// Glyph store: one write port, one read port with registered read data.
// Depends on bgb_pkg for the glyph row width.
module bgb_glyph_store
  import bgb_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BITS_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BITS_W-1:0] rd_data
);

  logic [BITS_W-1:0] mem [DEPTH];
  logic [BITS_W-1:0] rd_data_r;

  // Write a glyph row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a glyph row, hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/bitplane_glyph_blitter.sv
// Bitplane glyph blitter top level: config registers, draw sequencer and
// command output. Depends on bgb_pkg and bgb_glyph_store.
//
//   channel  ports                              handshake
//   input    start, busy, in_item               taken when start & !busy
//   output   out_valid, out_item                valid per command, no stall
//   config   cfg_we, cfg_index, cfg_wdata       taken when cfg_we
//
// A load item writes the store on accept and gives no command. A draw item
// with a nonzero row count passes the accept state, one for the line multiply,
// one for the base address and first store read, then one row state per
// command, and a split state for the second word of a row straddling a word.
// Each command leaves in the cycle after its row state. Reset sets only the
// state, valid and config registers; the store holds garbage until loaded.
module bitplane_glyph_blitter
  import bgb_pkg::*;
#(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int CW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // Rounded-up reciprocal of the glyph count, scaled by 2^16
  localparam int CODE_RECIP = (65536 + GLYPH_COUNT - 1) / GLYPH_COUNT;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_BASE  = 3'd2;
  localparam logic [2:0] ST_ROW   = 3'd3;
  localparam logic [2:0] ST_SPLIT = 3'd4;

  // Reduce a character code modulo the glyph count: quotient by reciprocal
  // multiply, then subtract quotient times count
  function automatic logic [CW-1:0] code_mod(input logic [7:0] code);
    logic [24:0] prod;
    logic [8:0]  quo;
    logic [17:0] back;
    logic [8:0]  rem;
    prod = {17'd0, code} * 25'(CODE_RECIP);
    quo  = prod[24:16];
    back = {9'd0, quo} * 18'(GLYPH_COUNT);
    rem  = {1'b0, code} - back[8:0];
    return CW'(rem);
  endfunction

  // Configuration registers
  logic [1:0]  plane_log2_r;
  logic [3:0]  glyph_width_r;
  logic [4:0]  glyph_height_r;
  logic [12:0] line_pixels_r;

  // Draw context
  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     code_r;
  logic [11:0]       px_r;
  logic [9:0]        py_r;
  logic [7:0]        fill_r;
  logic [RW-1:0]     rows_r;
  logic [RW-1:0]     row_r;
  logic [RW-1:0]     row_nx;
  logic              split_r;
  logic [3:0]        sh_r;
  logic [22:0]       prod_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] lw_r;

  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              accept;
  logic              is_last;
  logic [CW-1:0]     in_code;
  logic [RW-1:0]     in_rows;
  logic [5:0]        skew;
  logic [7:0]        in_fill;
  logic [23:0]       pix_sum;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] line_words;
  logic [ADDR_W-1:0] plane_step;
  logic [MASK_W-1:0] wide_bits;
  logic [MASK_W-1:0] mask_a;
  logic [MASK_W-1:0] mask_b;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BITS_W-1:0] rd_bits;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign in_code = code_mod(in_item.char_code);
  assign row_nx  = row_r + RW'(1);
  assign is_last = (row_nx == rows_r);

  // Saturate the row count, derive skew and plane fill for a new draw
  assign in_rows = ({1'b0, glyph_height_r} > 6'(MAX_GLYPH_ROWS)) ?
                   RW'(MAX_GLYPH_ROWS) : RW'(glyph_height_r);
  assign skew    = {2'b00, glyph_width_r} - {2'b00, in_item.pos_x[3:0]};

  always_comb begin
    case (plane_log2_r)
      2'd0:    in_fill = in_item.fg_color & 8'h01;
      2'd1:    in_fill = in_item.fg_color & 8'h03;
      2'd2:    in_fill = in_item.fg_color & 8'h0F;
      default: in_fill = in_item.fg_color;
    endcase
  end

  // Base address and line stride in plane-0 words
  assign pix_sum    = {1'b0, prod_r} + {12'd0, px_r};
  assign base_addr  = {2'b00, pix_sum[23:WORD_SHIFT]} << plane_log2_r;
  assign line_words = {13'd0, line_pixels_r[12:WORD_SHIFT]} << plane_log2_r;
  assign plane_step = ADDR_W'(1) << plane_log2_r;

  // Shift the glyph row into the one or two target words
  assign wide_bits = {{(MASK_W-BITS_W){1'b0}}, rd_bits};
  assign mask_a    = split_r ? (wide_bits >> sh_r) : (wide_bits << sh_r);
  assign mask_b    = wide_bits << (5'd16 - {1'b0, sh_r});

  // Store ports: load writes on accept, sequencer reads one row ahead
  assign wr_en   = accept && (in_item.func == FUNC_LOAD) &&
                   ({1'b0, in_item.glyph_row} < 5'(MAX_GLYPH_ROWS));
  assign wr_addr = AW'(int'(in_code) * MAX_GLYPH_ROWS + int'(in_item.glyph_row));
  assign rd_en   = (state_r == ST_BASE) ||
                   (state_r == ST_ROW && !split_r && !is_last) ||
                   (state_r == ST_SPLIT && !is_last);
  assign rd_addr = (state_r == ST_BASE) ?
                   AW'(int'(code_r) * MAX_GLYPH_ROWS + int'(row_r)) :
                   AW'(int'(code_r) * MAX_GLYPH_ROWS + int'(row_nx));

  bgb_glyph_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item.glyph_bits),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.func == FUNC_DRAW && in_rows != '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_ROW;
      ST_ROW: begin
        if (split_r) begin
          state_nxt = ST_SPLIT;
        end else if (is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SPLIT: state_nxt = is_last ? ST_IDLE : ST_ROW;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      plane_log2_r   <= RST_PLANE_LOG2;
      glyph_width_r  <= RST_GLYPH_WIDTH;
      glyph_height_r <= RST_GLYPH_HEIGHT;
      line_pixels_r  <= RST_LINE_PIXELS;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_ROW) || (state_r == ST_SPLIT);
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLANE_LOG2:   plane_log2_r   <= cfg_wdata[1:0];
          CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[3:0];
          CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[4:0];
          CFG_LINE_PIXELS:  line_pixels_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Draw context and command payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        code_r  <= in_code;
        px_r    <= in_item.pos_x;
        py_r    <= in_item.pos_y;
        fill_r  <= in_fill;
        rows_r  <= in_rows;
        row_r   <= '0;
        split_r <= skew[5];
        sh_r    <= skew[5] ? 4'(-skew) : skew[3:0];
      end
      ST_MUL: begin
        prod_r <= {13'd0, py_r} * {10'd0, line_pixels_r};
      end
      ST_BASE: begin
        addr_r <= base_addr;
        lw_r   <= line_words;
      end
      ST_ROW: begin
        out_item_r.word_address <= addr_r;
        out_item_r.bit_mask     <= mask_a;
        out_item_r.plane_fill   <= fill_r;
        out_item_r.last         <= !split_r && is_last;
        if (!split_r) begin
          addr_r <= addr_r + lw_r;
          row_r  <= row_nx;
        end
      end
      ST_SPLIT: begin
        out_item_r.word_address <= addr_r + plane_step;
        out_item_r.bit_mask     <= mask_b;
        out_item_r.plane_fill   <= fill_r;
        out_item_r.last         <= is_last;
        addr_r <= addr_r + lw_r;
        row_r  <= row_nx;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Second word of a row only follows its first word
  a_split_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SPLIT |-> $past(state_r) == ST_ROW)
    else $error("split word without first word");

  // The final command of a character leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last) |-> state_r == ST_IDLE)
    else $error("last command while still drawing");

  // Row counter stays inside the character while drawing
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW || state_r == ST_SPLIT) |-> row_r < rows_r)
    else $error("row counter past glyph height");

  // A command is only issued from a row state
  a_cmd_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_ROW || $past(state_r) == ST_SPLIT))
    else $error("command outside row states");

endmodule

// File: tb/bitplane_glyph_blitter_test.sv
// Self-checking testbench for bitplane_glyph_blitter: loads glyph rows, draws
// characters under many register settings and checks every write command.
// Depends on bgb_pkg and the blitter RTL only.
module bitplane_glyph_blitter_test;
  import bgb_pkg::*;

  localparam int STORE_ROWS  = 16;
  localparam int STORE_DEPTH = 256 * STORE_ROWS;
  localparam int DRAW_SETTLE = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Shadow of the block's registers and glyph store
  logic [1:0]  plane_log2_q;
  logic [3:0]  glyph_width_q;
  logic [4:0]  glyph_height_q;
  logic [12:0] line_pixels_q;
  logic [7:0]  font_rows [0:STORE_DEPTH-1];
  bit          font_loaded [0:STORE_DEPTH-1];

  out_item_t pending_cmds[$];
  int        error_count;
  int        idle_pct;

  bitplane_glyph_blitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Expand one draw into its write commands
  function automatic void predict_commands(input in_item_t it);
    int        planes;
    int        rows;
    int        skew;
    int        rs;
    int        bits_i;
    longint    line_words;
    longint    base;
    longint    addr;
    out_item_t cmd;
    planes     = 1 << plane_log2_q;
    rows       = (glyph_height_q > STORE_ROWS) ? STORE_ROWS : int'(glyph_height_q);
    skew       = int'(glyph_width_q) - int'(it.pos_x % 16);
    line_words = longint'(line_pixels_q >> WORD_SHIFT) * planes;
    base       = ((longint'(it.pos_y) * line_pixels_q + it.pos_x) >> WORD_SHIFT) * planes;
    cmd.plane_fill = 8'(int'(it.fg_color) & ((1 << planes) - 1));
    for (int r = 0; r < rows; r++) begin
      bits_i = font_rows[it.char_code * STORE_ROWS + r];
      addr   = base + r * line_words;
      cmd.word_address = ADDR_W'(addr);
      if (skew >= 0) begin
        cmd.bit_mask = 16'(bits_i << skew);
        cmd.last     = (r == rows - 1);
        pending_cmds.push_back(cmd);
      end else begin
        rs = -skew;
        cmd.bit_mask = 16'(bits_i >> rs);
        cmd.last     = 1'b0;
        pending_cmds.push_back(cmd);
        cmd.word_address = ADDR_W'(addr + planes);
        cmd.bit_mask     = 16'(bits_i << (16 - rs));
        cmd.last         = (r == rows - 1);
        pending_cmds.push_back(cmd);
      end
    end
  endfunction

  // Check each command against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected command at address", out_item.word_address, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_item.word_address !== want.word_address)
          report_mismatch("word_address", out_item.word_address, want.word_address);
        if (out_item.bit_mask !== want.bit_mask)
          report_mismatch("bit_mask", out_item.bit_mask, want.bit_mask);
        if (out_item.plane_fill !== want.plane_fill)
          report_mismatch("plane_fill", out_item.plane_fill, want.plane_fill);
        if (out_item.last !== want.last)
          report_mismatch("last", out_item.last, want.last);
      end
    end
  end

  // Offer one item, hold it until taken, then maybe idle a while
  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.func == FUNC_LOAD) begin
      font_rows[it.char_code * STORE_ROWS + it.glyph_row]   = it.glyph_bits;
      font_loaded[it.char_code * STORE_ROWS + it.glyph_row] = 1'b1;
    end else begin
      predict_commands(it);
    end
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic load_row(input logic [7:0] code, input logic [3:0] row, input logic [7:0] bits);
    in_item_t it;
    it            = random_item();
    it.func       = FUNC_LOAD;
    it.char_code  = code;
    it.glyph_row  = row;
    it.glyph_bits = bits;
    send_item(it);
  endtask

  // Fill any rows of a glyph that a draw at the current height would read
  task automatic prepare_glyph(input logic [7:0] code);
    int rows;
    rows = (glyph_height_q > STORE_ROWS) ? STORE_ROWS : int'(glyph_height_q);
    for (int r = 0; r < rows; r++)
      if (!font_loaded[code * STORE_ROWS + r])
        load_row(code, 4'(r), 8'($urandom));
  endtask

  task automatic draw_char(input logic [11:0] x, input logic [9:0] y,
                           input logic [7:0] code, input logic [7:0] fg);
    in_item_t it;
    prepare_glyph(code);
    it           = random_item();
    it.func      = FUNC_DRAW;
    it.pos_x     = x;
    it.pos_y     = y;
    it.char_code = code;
    it.fg_color  = fg;
    send_item(it);
  endtask

  // Drop start and wait for every expected command
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAW_SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic write_config(input logic [1:0] plane_log2, input logic [3:0] width,
                              input logic [4:0] height, input logic [12:0] line_px);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_PLANE_LOG2;   cfg_wdata <= CFG_W'(plane_log2);
    plane_log2_q = plane_log2;
    @(negedge clk);
    cfg_index <= CFG_GLYPH_WIDTH;  cfg_wdata <= CFG_W'(width);
    glyph_width_q = width;
    @(negedge clk);
    cfg_index <= CFG_GLYPH_HEIGHT; cfg_wdata <= CFG_W'(height);
    glyph_height_q = height;
    @(negedge clk);
    cfg_index <= CFG_LINE_PIXELS;  cfg_wdata <= line_px;
    line_pixels_q = line_px;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset values: one glyph and a stray row loaded, drawn aligned, at the far corner and split
  task automatic test_reset_config();
    logic [7:0] pattern [8];
    pattern = '{8'hFF, 8'h00, 8'h81, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h3C};
    for (int r = 0; r < 8; r++) load_row(8'hFF, 4'(r), pattern[r]);
    load_row(8'h00, 4'hF, 8'hFF);
    draw_char(12'd0, 10'd0, 8'hFF, 8'h00);
    draw_char(12'd4095, 10'd1023, 8'hFF, 8'hFF);
    draw_char(12'd9, 10'd5, 8'hFF, 8'h5A);
  endtask

  // Register extremes: zero height, wide skew, zero width with a zero line, one-word line
  task automatic test_register_extremes();
    write_config(2'd3, 4'd15, 5'd0, 13'd8191);
    draw_char(12'd100, 10'd7, 8'hFF, 8'hFF);
    write_config(2'd3, 4'd15, 5'd8, 13'd8191);
    draw_char(12'd0, 10'd1023, 8'hFF, 8'hC3);
    write_config(2'd2, 4'd0, 5'd8, 13'd0);
    draw_char(12'd1, 10'd3, 8'hFF, 8'hA5);
    write_config(2'd1, 4'd1, 5'd8, 13'd16);
    draw_char(12'd4095, 10'd1023, 8'hFF, 8'hFF);
  endtask

  // Random phases, each under its own register setting
  task automatic test_random_phases();
    in_item_t it;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_config(2'd0, 4'd1, 5'd1, 13'd16);
        1: write_config(2'd3, 4'd8, 5'd16, 13'd4096);
        2: write_config(2'd3, 4'd15, 5'd31, 13'd8191);
        3: write_config(2'd2, 4'd0, 5'd0, 13'd0);
        default: begin
          write_config(2'($urandom_range(3)),
                       ($urandom_range(99) < 80) ? 4'($urandom_range(1, 8))
                                                 : 4'($urandom_range(0, 15)),
                       ($urandom_range(99) < 80) ? 5'($urandom_range(1, 16))
                                                 : 5'($urandom_range(0, 31)),
                       ($urandom_range(99) < 80) ? 13'(16 * $urandom_range(1, 256))
                                                 : 13'($urandom_range(0, 8191)));
        end
      endcase
      // Hold a long stretch with no sender gaps
      idle_pct = (ph >= 4 && ph <= 6) ? 0 : 12;
      for (int n = 0; n < 20; n++) begin
        if (ph == 7 && n == 12) wait_drained();
        it = random_item();
        if ($urandom_range(99) < 70) begin
          // Draw from four glyphs so that few rows need loading first
          draw_char(it.pos_x, it.pos_y, 8'(85 * $urandom_range(3)), it.fg_color);
        end else begin
          it.func = FUNC_LOAD;
          send_item(it);
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PLANE_LOG2;
    cfg_wdata      = '0;
    error_count    = 0;
    idle_pct       = 12;
    plane_log2_q   = RST_PLANE_LOG2;
    glyph_width_q  = RST_GLYPH_WIDTH;
    glyph_height_q = RST_GLYPH_HEIGHT;
    line_pixels_q  = RST_LINE_PIXELS;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      font_rows[i]   = '0;
      font_loaded[i] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_register_extremes();
    test_random_phases();

    settle();
    if (pending_cmds.size() != 0)
      report_mismatch("commands never seen", 0, pending_cmds.size());
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
